>>> sv/imusbc_pkg.sv
// Shared types and constants for the IMU still-bias calibrator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package imusbc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = 16;
	localparam int OUT_W      = 16;
	localparam int STATUS_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_ROUND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_RANGE_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_TARGET       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_TOLERANCE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LIMIT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS        = 3'd6;

	typedef enum logic [STATUS_W-1:0] {
		STAT_COLLECT = 3'd0,
		STAT_ABORT   = 3'd1,
		STAT_REJECT  = 3'd2,
		STAT_CAL     = 3'd3,
		STAT_GAVEUP  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_COLLECT = 2'd0,
		PH_DONE    = 2'd1,
		PH_GAVEUP  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_NORM   = 3'd1,
		S_UPDATE = 3'd2,
		S_DIVIDE = 3'd3,
		S_CHECK  = 3'd4,
		S_FINISH = 3'd5
	} state_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage
`default_nettype wire

>>> sv/imu_still_bias_calibrator_unit.sv
// Top level of the IMU still-bias calibrator: config registers, round
// sequencer, result register. Uses imusbc_pkg, imusbc_norm and imusbc_div.
//
//  channel | signals                               | direction | transaction
//  --------+---------------------------------------+-----------+--------------------
//  s       | s_tvalid s_tready s_tdata s_tuser     | in        | one sample/restart
//  m       | m_tvalid m_tready m_tdata m_tuser     | out       | one result per item
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data| in        | one register write
//
// Steps: a restart, or a sample after the block has calibrated or given up,
// goes straight to the result. A collected sample runs a serial square, then a
// serial root, one bit a cycle; the sample that ends a round also runs the
// 4-lane serial divider and the check.
// Reset clears config to defaults and all round state; no clearing pass.
// The result register frees the input side: a new item is taken while the
// previous result waits; a result only stalls the sequencer if still unread.
`timescale 1ns / 1ps
`default_nettype none
module imu_still_bias_calibrator_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// accel_x, accel_y, accel_z, gyro_valid, gyro_x, gyro_y, gyro_z, zero fill
	input  logic [((6*SAMPLE_BITS+1+7)/8)*8-1:0]  s_tdata,
	// kind
	input  logic [0:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// bias_x, bias_y, bias_z, mean_norm, rounds_done
	output logic [5*imusbc_pkg::OUT_W-1:0]        m_tdata,
	// status
	output logic [imusbc_pkg::STATUS_W-1:0]       m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imusbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imusbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import imusbc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int NW = SB + 16;
	localparam int GW = SB + 17;
	localparam int WW = SB + 17;

	// configuration
	logic [15:0] spr_q, nlim_q, glim_q, ntgt_q, ntol_q, rounds_q;
	logic [14:0] offs_q;
	logic [15:0] spr_eff, rounds_eff;

	// round state
	state_t  state_q, state_d;
	phase_t  phase_q;
	status_t res_q;
	logic [CNT_W-1:0] scnt_q, rcnt_q;
	logic [NW-1:0]    nsum_q;
	logic [SB-1:0]    nlo_q, nhi_q, nstore_q;
	logic signed [GW-1:0] gsum_q [3];
	logic signed [SB-1:0] glo_q [3], ghi_q [3], lastg_q [3], bias_q [3];

	// captured input item
	logic                 in_gv_q;
	logic signed [SB-1:0] in_g_q [3];

	// output register
	logic                   m_valid_q;
	logic [5*OUT_W-1:0]     m_data_q;
	logic [STATUS_W-1:0]    m_user_q;

	unit_ctl_t norm_ctl, div_ctl;
	unit_sts_t norm_sts, div_sts;
	logic [SB-1:0] nrm, dv_norm;
	logic signed [SB-1:0] dv_bias [3];

	// update-cycle values
	logic signed [SB-1:0] geff [3], glo_n [3], ghi_n [3];
	logic signed [GW-1:0] gsum_n [3];
	logic [SB-1:0]  nlo_n, nhi_n;
	logic [NW-1:0]  nsum_n;
	logic [CNT_W:0] scnt_n;
	logic [CNT_W-1:0] rcnt_inc;
	logic [WW-1:0]  gdiff, ndist, babs;
	logic           first, bad, round_end, fit, s_acc, out_free;

	assign s_acc     = s_tvalid && s_tready;
	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign spr_eff    = (spr_q == '0) ? 16'd1 : spr_q;
	assign rounds_eff = (rounds_q == '0) ? 16'd1 : rounds_q;
	assign rcnt_inc   = (rcnt_q == '1) ? rcnt_q : rcnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q    <= 16'd6000;
			nlim_q   <= 16'd390;
			glim_q   <= 16'd141;
			ntgt_q   <= 16'd5463;
			ntol_q   <= 16'd279;
			offs_q   <= 15'd9;
			rounds_q <= 16'd2000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLES_PER_ROUND: spr_q    <= cfg_data;
				REG_NORM_RANGE_LIMIT:  nlim_q   <= cfg_data;
				REG_GYRO_RANGE_LIMIT:  glim_q   <= cfg_data;
				REG_NORM_TARGET:       ntgt_q   <= cfg_data;
				REG_NORM_TOLERANCE:    ntol_q   <= cfg_data;
				REG_OFFSET_LIMIT:      offs_q   <= cfg_data[14:0];
				REG_MAX_ROUNDS:        rounds_q <= cfg_data;
				default: ;
			endcase
		end
	end

	imusbc_norm #(.SAMPLE_BITS(SB)) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (norm_ctl),
		.sts     (norm_sts),
		.accel_x (s_tdata[SB-1:0]),
		.accel_y (s_tdata[2*SB-1:SB]),
		.accel_z (s_tdata[3*SB-1:2*SB]),
		.norm    (nrm)
	);

	imusbc_div #(.SAMPLE_BITS(SB)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (div_ctl),
		.sts        (div_sts),
		.divisor    (scnt_n[CNT_W-1:0]),
		.norm_sum   (nsum_n),
		.gyro_sum_x (gsum_n[0]),
		.gyro_sum_y (gsum_n[1]),
		.gyro_sum_z (gsum_n[2]),
		.mean_norm  (dv_norm),
		.bias_x     (dv_bias[0]),
		.bias_y     (dv_bias[1]),
		.bias_z     (dv_bias[2])
	);

	// per-sample min/max, sums and stillness check
	always_comb begin
		first  = scnt_q == '0;
		nlo_n  = (first || nrm < nlo_q) ? nrm : nlo_q;
		nhi_n  = (first || nrm > nhi_q) ? nrm : nhi_q;
		nsum_n = nsum_q + NW'(nrm);
		bad    = WW'(nhi_n - nlo_n) > WW'(nlim_q);
		gdiff  = '0;
		for (int i = 0; i < 3; i++) begin
			geff[i]   = in_gv_q ? in_g_q[i] : lastg_q[i];
			glo_n[i]  = (first || geff[i] < glo_q[i]) ? geff[i] : glo_q[i];
			ghi_n[i]  = (first || geff[i] > ghi_q[i]) ? geff[i] : ghi_q[i];
			gsum_n[i] = in_gv_q ? gsum_q[i] + GW'(in_g_q[i]) : gsum_q[i];
			gdiff     = WW'(ghi_n[i]) - WW'(glo_n[i]);
			if (gdiff > WW'(glim_q)) begin
				bad = 1'b1;
			end
		end
		scnt_n    = {1'b0, scnt_q} + 1'b1;
		round_end = scnt_n >= {1'b0, spr_eff};
		// acceptance test on the stored means
		ndist = (WW'(nstore_q) >= WW'(ntgt_q)) ? WW'(nstore_q) - WW'(ntgt_q)
			: WW'(ntgt_q) - WW'(nstore_q);
		fit   = ndist <= WW'(ntol_q);
		babs  = '0;
		for (int i = 0; i < 3; i++) begin
			babs = bias_q[i][SB-1] ? WW'(0) - WW'(bias_q[i]) : WW'(bias_q[i]);
			if (babs > WW'(offs_q)) begin
				fit = 1'b0;
			end
		end
	end

	// sequencer next state and unit starts
	always_comb begin
		state_d        = state_q;
		norm_ctl.start = 1'b0;
		div_ctl.start  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					if (!s_tuser[0] && phase_q == PH_COLLECT) begin
						norm_ctl.start = 1'b1;
						state_d        = S_NORM;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_NORM: begin
				if (norm_sts.done) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (!bad && round_end) begin
					div_ctl.start = 1'b1;
					state_d       = S_DIVIDE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIVIDE: begin
				if (div_sts.done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// round state; cleared on reset since its reset values are visible
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COLLECT;
			res_q    <= STAT_COLLECT;
			scnt_q   <= '0;
			rcnt_q   <= '0;
			nsum_q   <= '0;
			nlo_q    <= '0;
			nhi_q    <= '0;
			nstore_q <= '0;
			for (int i = 0; i < 3; i++) begin
				gsum_q[i]  <= '0;
				glo_q[i]   <= '0;
				ghi_q[i]   <= '0;
				lastg_q[i] <= '0;
				bias_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (s_tuser[0]) begin
							phase_q <= PH_COLLECT;
							res_q   <= STAT_COLLECT;
							scnt_q  <= '0;
							rcnt_q  <= '0;
							nsum_q  <= '0;
							nlo_q   <= '0;
							nhi_q   <= '0;
							for (int i = 0; i < 3; i++) begin
								gsum_q[i] <= '0;
								glo_q[i]  <= '0;
								ghi_q[i]  <= '0;
							end
						end else if (phase_q == PH_DONE) begin
							res_q <= STAT_CAL;
						end else if (phase_q == PH_GAVEUP) begin
							res_q <= STAT_GAVEUP;
						end
					end
				end
				S_UPDATE: begin
					for (int i = 0; i < 3; i++) begin
						lastg_q[i] <= geff[i];
					end
					if (bad) begin
						rcnt_q <= rcnt_inc;
						scnt_q <= '0;
						nsum_q <= '0;
						nlo_q  <= '0;
						nhi_q  <= '0;
						for (int i = 0; i < 3; i++) begin
							gsum_q[i] <= '0;
							glo_q[i]  <= '0;
							ghi_q[i]  <= '0;
						end
						if (rcnt_inc >= rounds_eff) begin
							phase_q <= PH_GAVEUP;
							res_q   <= STAT_GAVEUP;
						end else begin
							res_q <= STAT_ABORT;
						end
					end else begin
						scnt_q <= scnt_n[CNT_W-1:0];
						nsum_q <= nsum_n;
						nlo_q  <= nlo_n;
						nhi_q  <= nhi_n;
						res_q  <= STAT_COLLECT;
						for (int i = 0; i < 3; i++) begin
							gsum_q[i] <= gsum_n[i];
							glo_q[i]  <= glo_n[i];
							ghi_q[i]  <= ghi_n[i];
						end
					end
				end
				S_DIVIDE: begin
					if (div_sts.done) begin
						nstore_q <= dv_norm;
						rcnt_q   <= rcnt_inc;
						for (int i = 0; i < 3; i++) begin
							bias_q[i] <= dv_bias[i];
						end
					end
				end
				S_CHECK: begin
					scnt_q <= '0;
					nsum_q <= '0;
					nlo_q  <= '0;
					nhi_q  <= '0;
					for (int i = 0; i < 3; i++) begin
						gsum_q[i] <= '0;
						glo_q[i]  <= '0;
						ghi_q[i]  <= '0;
					end
					if (fit) begin
						phase_q <= PH_DONE;
						res_q   <= STAT_CAL;
					end else if (rcnt_q >= rounds_eff) begin
						phase_q <= PH_GAVEUP;
						res_q   <= STAT_GAVEUP;
					end else begin
						res_q <= STAT_REJECT;
					end
				end
				default: ;
			endcase
		end
	end

	// gyro fields of the accepted item, used in the update cycle
	always_ff @(posedge clk) begin
		if (s_acc) begin
			in_gv_q   <= s_tdata[3*SB];
			in_g_q[0] <= s_tdata[4*SB:3*SB+1];
			in_g_q[1] <= s_tdata[5*SB:4*SB+1];
			in_g_q[2] <= s_tdata[6*SB:5*SB+1];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			m_user_q <= res_q;
			m_data_q <= {rcnt_q, OUT_W'(nstore_q), OUT_W'(bias_q[2]),
				OUT_W'(bias_q[1]), OUT_W'(bias_q[0])};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	a_norm_done_in_norm: assert property (@(posedge clk) disable iff (!arst_n)
		norm_sts.done |-> state_q == S_NORM)
		else $error("norm unit finished outside its wait state");

	a_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == S_DIVIDE)
		else $error("divider finished outside its wait state");

	a_norm_busy_in_norm: assert property (@(posedge clk) disable iff (!arst_n)
		norm_sts.busy |-> state_q == S_NORM)
		else $error("norm unit busy outside its wait state");

	a_div_busy_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> state_q == S_DIVIDE)
		else $error("divider busy outside its wait state");

	a_done_round_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_COLLECT |-> scnt_q == '0)
		else $error("sample count left nonzero after calibration ended");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q != S_IDLE)
		else $error("accepted transaction did not start work");

endmodule
`default_nettype wire

>>> sv/imusbc_norm.sv
// Serial accelerometer norm: bit-serial sum of squares, then digit-by-digit
// integer square root. Depends on imusbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imusbc_norm #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  imusbc_pkg::unit_ctl_t         ctl,
	output imusbc_pkg::unit_sts_t         sts,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	output logic [SAMPLE_BITS-1:0]        norm
);
	import imusbc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int RW = 2 * SB;
	localparam int CW = $clog2(SB);

	logic          busy_q, root_ph_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [SB-1:0] mx_q, my_q, mz_q, bx_q, by_q, bz_q, root_q;
	logic [RW-1:0] acc_q, acc_sq;
	logic [SB+1:0] rem_q, rem_sh, trial;
	logic          ge, last;

	function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
		mag = v[SB-1] ? SB'(-v) : SB'(v);
	endfunction

	always_comb begin
		acc_sq = {acc_q[RW-2:0], 1'b0}
			+ RW'(bx_q[SB-1] ? mx_q : '0)
			+ RW'(by_q[SB-1] ? my_q : '0)
			+ RW'(bz_q[SB-1] ? mz_q : '0);
		rem_sh = {rem_q[SB-1:0], acc_q[RW-1:RW-2]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
		last   = cnt_q == CW'(SB - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			root_ph_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q    <= 1'b1;
				root_ph_q <= 1'b0;
				cnt_q     <= '0;
			end else if (busy_q) begin
				cnt_q <= last ? '0 : cnt_q + 1'b1;
				if (last) begin
					if (root_ph_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						root_ph_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mx_q  <= mag(accel_x);
			my_q  <= mag(accel_y);
			mz_q  <= mag(accel_z);
			bx_q  <= mag(accel_x);
			by_q  <= mag(accel_y);
			bz_q  <= mag(accel_z);
			acc_q <= '0;
		end else if (busy_q && !root_ph_q) begin
			acc_q <= acc_sq;
			bx_q  <= {bx_q[SB-2:0], 1'b0};
			by_q  <= {by_q[SB-2:0], 1'b0};
			bz_q  <= {bz_q[SB-2:0], 1'b0};
			if (last) begin
				rem_q  <= '0;
				root_q <= '0;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[SB-2:0], ge};
			acc_q  <= {acc_q[RW-3:0], 2'b00};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign norm     = root_q;

endmodule
`default_nettype wire

>>> sv/imusbc_div.sv
// Four-lane restoring divider sharing one 16-bit divisor, one quotient bit
// per cycle per lane; gyro lanes divide magnitudes. Depends on imusbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imusbc_div #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  imusbc_pkg::unit_ctl_t            ctl,
	output imusbc_pkg::unit_sts_t            sts,
	input  logic [imusbc_pkg::CNT_W-1:0]     divisor,
	input  logic [SAMPLE_BITS+15:0]          norm_sum,
	input  logic signed [SAMPLE_BITS+16:0]   gyro_sum_x,
	input  logic signed [SAMPLE_BITS+16:0]   gyro_sum_y,
	input  logic signed [SAMPLE_BITS+16:0]   gyro_sum_z,
	output logic [SAMPLE_BITS-1:0]           mean_norm,
	output logic signed [SAMPLE_BITS-1:0]    bias_x,
	output logic signed [SAMPLE_BITS-1:0]    bias_y,
	output logic signed [SAMPLE_BITS-1:0]    bias_z
);
	import imusbc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int NW = SB + 16;
	localparam int GW = SB + 17;
	localparam int CW = $clog2(NW);
	localparam int LANES = 4;

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W:0]   rem_q [LANES];
	logic [NW-1:0]    dq_q  [LANES];
	logic [2:0]       neg_q;
	logic [CNT_W:0]   rem_sh [LANES];
	logic [LANES-1:0] ge;
	logic [NW-1:0]    dvd [LANES];
	logic signed [GW-1:0] gsum [3];
	logic [SB-1:0]    q [3];
	logic             last;

	function automatic logic [NW-1:0] gmag(input logic signed [GW-1:0] v);
		gmag = v[GW-1] ? NW'(-v) : NW'(v);
	endfunction

	always_comb begin
		gsum[0] = gyro_sum_x;
		gsum[1] = gyro_sum_y;
		gsum[2] = gyro_sum_z;
		dvd[0]  = norm_sum;
		for (int i = 0; i < 3; i++) begin
			dvd[i+1] = gmag(gsum[i]);
		end
		for (int l = 0; l < LANES; l++) begin
			rem_sh[l] = {rem_q[l][CNT_W-1:0], dq_q[l][NW-1]};
			ge[l]     = rem_sh[l] >= {1'b0, div_q};
		end
		last = cnt_q == CW'(NW - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= last ? '0 : cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= divisor;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
				dq_q[l]  <= dvd[l];
			end
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= gsum[i][GW-1];
			end
		end else if (busy_q) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= ge[l] ? rem_sh[l] - {1'b0, div_q} : rem_sh[l];
				dq_q[l]  <= {dq_q[l][NW-2:0], ge[l]};
			end
		end
	end

	// quotients fit SB bits: means never exceed the sample range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q[i] = neg_q[i] ? SB'(-dq_q[i+1]) : SB'(dq_q[i+1]);
		end
	end

	assign mean_norm = SB'(dq_q[0]);
	assign bias_x    = q[0];
	assign bias_y    = q[1];
	assign bias_z    = q[2];
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

endmodule
`default_nettype wire
